>>> rtl/srhd_pkg.sv
`default_nettype none

package srhd_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int SMOOTH_DIV     = 4;
    localparam int SMOOTH_SHIFT   = $clog2(SMOOTH_DIV);

    localparam int SOURCE_W  = 8;
    localparam int LEVEL_W   = 12;
    localparam int CONFIRM_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 2'd2;

    localparam logic [LEVEL_W-1:0]   TRIGGER_RST = 12'd64;
    localparam logic [LEVEL_W-1:0]   RELEASE_RST = 12'd16;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 8'd15;
    localparam logic [CONFIRM_W-1:0] CALM_MAX    = 8'd255;

    typedef struct packed {
        logic [LEVEL_W-1:0]   trigger_level;
        logic [LEVEL_W-1:0]   release_level;
        logic [CONFIRM_W-1:0] confirm_frames;
    } srhd_cfg_t;

endpackage

`default_nettype wire

>>> rtl/srhd_if.sv
`default_nettype none

interface srhd_sample_if
    import srhd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  active;
    logic [SOURCE_W-1:0]   source_id;
    logic [ANGLE_BITS-1:0] heading;

    modport source (output valid, output active, output source_id, output heading,
                    input ready);
    modport sink (input valid, input active, input source_id, input heading,
                  output ready);
endinterface

interface srhd_result_if
    import srhd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  unstable;
    logic [ANGLE_BITS-1:0] smoothed_rate;

    modport source (output valid, output unstable, output smoothed_rate, input ready);
    modport sink (input valid, input unstable, input smoothed_rate, output ready);
endinterface

`default_nettype wire

>>> rtl/srhd_cfg.sv
`default_nettype none

module srhd_cfg
    import srhd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output srhd_cfg_t                  cfg
);

    srhd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level  <= TRIGGER_RST;
            cfg_reg.release_level  <= RELEASE_RST;
            cfg_reg.confirm_frames <= CONFIRM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIGGER: cfg_reg.trigger_level  <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE: cfg_reg.release_level  <= cfg_data[LEVEL_W-1:0];
                REG_CONFIRM: cfg_reg.confirm_frames <= cfg_data[CONFIRM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/srhd_core.sv
`default_nettype none

module srhd_core
    import srhd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire srhd_cfg_t             cfg,
    input  wire logic                  active,
    input  wire logic [SOURCE_W-1:0]   source_id,
    input  wire logic [ANGLE_BITS-1:0] heading,
    output logic                       unstable_next,
    output logic [ANGLE_BITS-1:0]      rate_next
);

    localparam int CMP_W = (ANGLE_BITS > LEVEL_W) ? ANGLE_BITS : LEVEL_W;

    logic                  known_reg, known_next;
    logic [SOURCE_W-1:0]   source_reg, source_next;
    logic [ANGLE_BITS-1:0] prev_reg, prev_next;
    logic [ANGLE_BITS-1:0] rate_reg;
    logic                  hold_reg;
    logic [CONFIRM_W-1:0]  calm_reg, calm_next;

    logic [ANGLE_BITS-1:0] diff;
    logic [ANGLE_BITS-1:0] abs_diff;
    logic [ANGLE_BITS:0]   delta;
    logic [ANGLE_BITS-1:0] delta_mag;
    logic [ANGLE_BITS-1:0] step_mag;
    logic [ANGLE_BITS-1:0] rate_smooth;
    logic [CMP_W-1:0]      rate_cmp;
    logic [CONFIRM_W-1:0]  calm_inc;

    always_comb
    begin
        diff        = prev_reg - heading;
        abs_diff    = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
        delta       = {1'b0, abs_diff} - {1'b0, rate_reg};
        delta_mag   = delta[ANGLE_BITS] ? ANGLE_BITS'(~delta + 1'b1)
                                        : delta[ANGLE_BITS-1:0];
        step_mag    = delta_mag >> SMOOTH_SHIFT;
        rate_smooth = delta[ANGLE_BITS] ? (rate_reg - step_mag) : (rate_reg + step_mag);

        known_next  = known_reg;
        source_next = source_reg;
        prev_next   = prev_reg;
        rate_next   = rate_reg;
        unstable_next = hold_reg;
        calm_next   = calm_reg;
        calm_inc    = (calm_reg == CALM_MAX) ? CALM_MAX : (calm_reg + 1'b1);

        if (active)
        begin
            if (!known_reg || (source_reg != source_id))
            begin
                known_next  = 1'b1;
                source_next = source_id;
                prev_next   = heading;
                rate_next   = '0;
            end
            else
            begin
                prev_next = heading;
                rate_next = rate_smooth;
            end

            rate_cmp = CMP_W'(rate_next);
            calm_inc = (calm_reg == CALM_MAX) ? CALM_MAX : (calm_reg + 1'b1);

            if (!hold_reg && (rate_cmp > CMP_W'(cfg.trigger_level)))
            begin
                unstable_next = 1'b1;
                calm_next     = '0;
            end
            else if (hold_reg)
            begin
                if (rate_cmp <= CMP_W'(cfg.release_level))
                begin
                    calm_next = calm_inc;
                    if (calm_inc >= cfg.confirm_frames)
                    begin
                        unstable_next = 1'b0;
                    end
                end
                else
                begin
                    calm_next = '0;
                end
            end
        end
        else
        begin
            rate_cmp      = '0;
            known_next    = 1'b0;
            rate_next     = '0;
            unstable_next = 1'b0;
            calm_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg  <= 1'b0;
            source_reg <= '0;
            prev_reg   <= '0;
            rate_reg   <= '0;
            hold_reg   <= 1'b0;
            calm_reg   <= '0;
        end
        else if (step)
        begin
            known_reg  <= known_next;
            source_reg <= source_next;
            prev_reg   <= prev_next;
            rate_reg   <= rate_next;
            hold_reg   <= unstable_next;
            calm_reg   <= calm_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/spin_rate_hysteresis_detector.sv
// Spin-rate hysteresis detector. Each sample transfer carries an active flag, a source
// identifier and a heading; each one yields exactly one result transfer with the unstable
// flag and the smoothed rate after that frame. A sample is captured in an input register,
// processed combinationally against the tracking state, and the result is held in an
// output register, from which it is offered on the result side. The block sustains one
// sample per clock cycle as long as the result side keeps taking transfers; ready on the
// sample side follows the output register's ready through the input register.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
`default_nettype none

module spin_rate_hysteresis_detector
    import srhd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    srhd_sample_if.sink                sample,
    srhd_result_if.source              result
);

    srhd_cfg_t cfg;

    logic                  s_valid_reg;
    logic                  s_active_reg;
    logic [SOURCE_W-1:0]   s_source_reg;
    logic [ANGLE_BITS-1:0] s_heading_reg;

    logic                  r_valid_reg;
    logic                  r_unstable_reg;
    logic [ANGLE_BITS-1:0] r_rate_reg;

    logic                  result_free;
    logic                  step;
    logic                  take;
    logic                  unstable_next;
    logic [ANGLE_BITS-1:0] rate_next;

    assign result_free  = !r_valid_reg || result.ready;
    assign step         = s_valid_reg && result_free;
    assign sample.ready = !s_valid_reg || result_free;
    assign take         = sample.valid && sample.ready;

    srhd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srhd_core #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cfg           (cfg),
        .active        (s_active_reg),
        .source_id     (s_source_reg),
        .heading       (s_heading_reg),
        .unstable_next (unstable_next),
        .rate_next     (rate_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s_valid_reg <= sample.valid;
            end
            if (result_free)
            begin
                r_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_active_reg  <= sample.active;
            s_source_reg  <= sample.source_id;
            s_heading_reg <= sample.heading;
        end
        if (step)
        begin
            r_unstable_reg <= unstable_next;
            r_rate_reg     <= rate_next;
        end
    end

    assign result.valid         = r_valid_reg;
    assign result.unstable      = r_unstable_reg;
    assign result.smoothed_rate = r_rate_reg;

endmodule

`default_nettype wire
